@@ sv/rgbl_pkg.sv @@
package rgbl_pkg;

  // Mode codes as held in the mode register and reported on active_mode.
  localparam logic [1:0] MODE_SOLID   = 2'd0;
  localparam logic [1:0] MODE_BLINK   = 2'd1;
  localparam logic [1:0] MODE_BREATHE = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_BACKGROUND  = 3'd1;
  localparam logic [2:0] REG_FLASH       = 3'd2;
  localparam logic [2:0] REG_ON_TIME     = 3'd3;
  localparam logic [2:0] REG_OFF_TIME    = 3'd4;
  localparam logic [2:0] REG_BLINK_COUNT = 3'd5;
  localparam logic [2:0] REG_RISE_SPEED  = 3'd6;
  localparam logic [2:0] REG_FALL_SPEED  = 3'd7;

  // Breathing ramp constants.
  localparam logic [7:0] RAMP_TOP       = 8'd200;
  localparam logic [7:0] RAMP_MID       = 8'd100;
  localparam logic [7:0] RAMP_HIGH_EDGE = 8'd195;
  localparam logic [7:0] SPEED_SPLIT    = 8'd5;
  localparam logic [6:0] DUTY_FLOOR     = 7'd3;

  // Bound on the blink tick counter, which stays below 2*(255+255).
  localparam logic [10:0] TICK_MAX = 11'd1020;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] background_color;
    logic [2:0] blink_color;
    logic [7:0] on_time;
    logic [7:0] off_time;
    logic [7:0] blink_count;
    logic [7:0] rise_speed;
    logic [7:0] fall_speed;
  } cfg_t;

  typedef struct packed {
    logic [2:0] pins_n;      // bit0 red, bit1 green, bit2 blue
    logic       pwm_enable;
    logic [6:0] duty;
    logic [1:0] active_mode;
  } result_t;

endpackage

@@ sv/rgbl_cfg.sv @@
module rgbl_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output rgbl_pkg::cfg_t    cfg,
  output logic              restart
);

  // Register file, masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rgbl_pkg::REG_MODE:        cfg.mode             <= cfg_data[1:0];
        rgbl_pkg::REG_BACKGROUND:  cfg.background_color <= cfg_data[2:0];
        rgbl_pkg::REG_FLASH:       cfg.blink_color      <= cfg_data[2:0];
        rgbl_pkg::REG_ON_TIME:     cfg.on_time          <= cfg_data;
        rgbl_pkg::REG_OFF_TIME:    cfg.off_time         <= cfg_data;
        rgbl_pkg::REG_BLINK_COUNT: cfg.blink_count      <= cfg_data;
        rgbl_pkg::REG_RISE_SPEED:  cfg.rise_speed       <= cfg_data;
        rgbl_pkg::REG_FALL_SPEED:  cfg.fall_speed       <= cfg_data;
        default:                   cfg                  <= cfg;
      endcase
    end
  end

  // Any write restarts the run state; restart is registered, so it rises once the new value is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b0;
    end else begin
      restart <= cfg_write;
    end
  end

endmodule

@@ sv/rgbl_engine.sv @@
module rgbl_engine (
  input  logic              clk,
  input  logic              rst,
  input  rgbl_pkg::cfg_t    cfg,
  input  logic              restart,
  input  logic              step,
  input  logic              tick,
  output rgbl_pkg::result_t res
);

  logic [1:0]  run_mode, run_mode_next;
  logic        shown_valid, shown_valid_next;
  logic [2:0]  pin_levels, pin_levels_next;
  logic [10:0] tick_count, tick_count_next;
  logic [7:0]  periods_left, periods_left_next;
  logic [7:0]  ramp_index, ramp_index_next;
  logic [7:0]  ramp_prescale, ramp_prescale_next;
  logic [6:0]  duty_level, duty_level_next;
  logic        pwm_on, pwm_on_next;

  logic [10:0] tick_inc;
  logic [10:0] on_end;
  logic [10:0] period_end;
  logic        rising;
  logic [7:0]  speed;
  logic [7:0]  limit;
  logic [7:0]  ramp_sum;
  logic [7:0]  prescale_inc;
  logic [7:0]  ramp_new;

  // Blink timing: one counter compared against the on and period ends.
  assign tick_inc   = tick_count + 11'd1;
  assign on_end     = {2'b00, cfg.on_time, 1'b0};
  assign period_end = {2'b00, cfg.on_time, 1'b0} + {2'b00, cfg.off_time, 1'b0};

  // Breathing ramp: the phase picks its speed and its upper limit.
  assign rising       = (ramp_index < rgbl_pkg::RAMP_MID);
  assign speed        = rising ? cfg.rise_speed : cfg.fall_speed;
  assign limit        = rising ? rgbl_pkg::RAMP_MID : rgbl_pkg::RAMP_TOP;
  assign ramp_sum     = ramp_index + (rgbl_pkg::SPEED_SPLIT - speed);
  assign prescale_inc = ramp_prescale + 8'd1;

  always_comb begin
    run_mode_next      = run_mode;
    shown_valid_next   = shown_valid;
    pin_levels_next    = pin_levels;
    tick_count_next    = tick_count;
    periods_left_next  = periods_left;
    ramp_index_next    = ramp_index;
    ramp_prescale_next = ramp_prescale;
    duty_level_next    = duty_level;
    pwm_on_next        = pwm_on;
    ramp_new           = ramp_index;

    if (restart) begin
      // Restart after a register write; the pins keep their levels.
      run_mode_next      = (cfg.mode == rgbl_pkg::MODE_UNUSED) ? rgbl_pkg::MODE_SOLID
                                                               : cfg.mode;
      shown_valid_next   = 1'b0;
      tick_count_next    = '0;
      periods_left_next  = cfg.blink_count;
      ramp_index_next    = '0;
      ramp_prescale_next = '0;
      duty_level_next    = '0;
      pwm_on_next        = (cfg.mode == rgbl_pkg::MODE_BREATHE);
    end else if (step && tick) begin
      case (run_mode)
        rgbl_pkg::MODE_BLINK: begin
          tick_count_next = tick_inc;
          if (tick_inc == 11'd1) begin
            pin_levels_next = ~cfg.blink_color;
          end else if (tick_inc == on_end) begin
            pin_levels_next = ~cfg.background_color;
          end else if (tick_inc >= period_end) begin
            tick_count_next = '0;
            if (periods_left != 8'd0) begin
              periods_left_next = periods_left - 8'd1;
            end
          end
          // A counted run that has just used its last period falls back to solid.
          if ((periods_left != 8'd0) && (periods_left_next == 8'd0)) begin
            shown_valid_next = 1'b0;
            tick_count_next  = '0;
            run_mode_next    = rgbl_pkg::MODE_SOLID;
            pwm_on_next      = 1'b0;
          end
        end
        rgbl_pkg::MODE_BREATHE: begin
          if (ramp_index < rgbl_pkg::RAMP_TOP) begin
            if (speed < rgbl_pkg::SPEED_SPLIT) begin
              ramp_new = (ramp_sum > limit) ? limit : ramp_sum;
            end else if (prescale_inc >= speed - rgbl_pkg::SPEED_SPLIT) begin
              ramp_prescale_next = '0;
              ramp_new           = ramp_index + 8'd1;
            end else begin
              ramp_prescale_next = prescale_inc;
            end
            ramp_index_next = ramp_new;
            if (rising) begin
              duty_level_next = (ramp_new < rgbl_pkg::SPEED_SPLIT) ? rgbl_pkg::DUTY_FLOOR
                                                                   : ramp_new[6:0];
            end else if (ramp_new > rgbl_pkg::RAMP_HIGH_EDGE) begin
              duty_level_next = rgbl_pkg::DUTY_FLOOR;
            end else begin
              duty_level_next = 7'(rgbl_pkg::RAMP_TOP - ramp_new);
            end
          end else begin
            ramp_index_next = '0;
            duty_level_next = '0;
          end
        end
        default: begin
          // Solid: write the background colour once after reset, each restart or the end of a counted blink run.
          if (!shown_valid) begin
            pin_levels_next  = ~cfg.background_color;
            shown_valid_next = 1'b1;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= rgbl_pkg::MODE_SOLID;
      shown_valid   <= 1'b0;
      pin_levels    <= 3'b111;
      tick_count    <= '0;
      periods_left  <= '0;
      ramp_index    <= '0;
      ramp_prescale <= '0;
      duty_level    <= '0;
      pwm_on        <= 1'b0;
    end else begin
      run_mode      <= run_mode_next;
      shown_valid   <= shown_valid_next;
      pin_levels    <= pin_levels_next;
      tick_count    <= tick_count_next;
      periods_left  <= periods_left_next;
      ramp_index    <= ramp_index_next;
      ramp_prescale <= ramp_prescale_next;
      duty_level    <= duty_level_next;
      pwm_on        <= pwm_on_next;
    end
  end

  // The result reports the state as it stands after this request.
  assign res.pins_n      = pin_levels_next;
  assign res.pwm_enable  = pwm_on_next;
  assign res.duty        = duty_level_next;
  assign res.active_mode = run_mode_next;

`ifndef SYNTH
  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    ramp_index <= rgbl_pkg::RAMP_TOP)
    else $error("ramp index beyond its top");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_level <= 7'(rgbl_pkg::RAMP_MID))
    else $error("duty above one hundred percent");

  a_pwm_mode: assert property (@(posedge clk) disable iff (rst)
    pwm_on == (run_mode == rgbl_pkg::MODE_BREATHE))
    else $error("pwm enable disagrees with the running mode");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_count <= rgbl_pkg::TICK_MAX)
    else $error("blink counter ran past the longest period");

  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    restart |=> (tick_count == 11'd0) && (ramp_index == 8'd0) && !shown_valid)
    else $error("restart did not clear the run state");
`endif

endmodule

@@ sv/rgb_led_blink_breathe_controller.sv @@
// RGB LED blink and breathing controller. Each request carries one tick bit
// (one 10 ms tick when set, a plain status read when clear) and returns exactly
// one result with the active-low pin levels, the PWM enable, the breathing duty
// and the running mode. A request passes an input register and then the state
// update, whose outcome lands in the output register that offers the result;
// both registers hold while a result waits for out_ready. A new request is
// taken in every cycle while results are being collected, so the sustained
// rate is one request per cycle. Register writes restart the run state through
// a registered pulse and must be made while no request is in flight.
module rgb_led_blink_breathe_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       red_pin_n,
  output logic       green_pin_n,
  output logic       blue_pin_n,
  output logic       pwm_enable,
  output logic [6:0] duty,
  output logic [1:0] active_mode
);

  rgbl_pkg::cfg_t    cfg;
  rgbl_pkg::result_t res;
  rgbl_pkg::result_t out_res;
  logic              restart;
  logic              s1_valid;
  logic              s1_tick;
  logic              advance;
  logic              step;

  rgbl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  // Handshake: the input stage moves on whenever the output register is free.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tick <= tick;
    end
  end

  rgbl_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .step    (step),
    .tick    (s1_tick),
    .res     (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign red_pin_n   = out_res.pins_n[0];
  assign green_pin_n = out_res.pins_n[1];
  assign blue_pin_n  = out_res.pins_n[2];
  assign pwm_enable  = out_res.pwm_enable;
  assign duty        = out_res.duty;
  assign active_mode = out_res.active_mode;

endmodule

@@ test/tb_rgb_led_blink_breathe_controller.sv @@
module tb_rgb_led_blink_breathe_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int HOLD_PHASE    = 3;
  localparam int PHASE_COUNT   = 12;
  localparam int MAX_REPORTS   = 10;
  localparam logic [3:0] COLOR_NONE = 4'd8;

  typedef enum logic [1:0] {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;
  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        index;
    logic [7:0]        data;
    logic              has_lit;
    rgbl_pkg::result_t lit;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       tick = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       red_pin_n;
  logic       green_pin_n;
  logic       blue_pin_n;
  logic       pwm_enable;
  logic [6:0] duty;
  logic [1:0] active_mode;

  rgb_led_blink_breathe_controller dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .tick(tick),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red_pin_n(red_pin_n),
    .green_pin_n(green_pin_n),
    .blue_pin_n(blue_pin_n),
    .pwm_enable(pwm_enable),
    .duty(duty),
    .active_mode(active_mode)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shared between the request side and the result side.
  rgbl_pkg::result_t led_expected_q[$];
  plan_row_t         plan_q[$];
  logic [10:0]       pending_writes[$];
  int                fail_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                phase_num = -1;

  // Predicted copy of the registers and of the run state.
  rgbl_pkg::cfg_t regs;
  logic [1:0] run_state;
  logic [3:0] shown;
  logic [2:0] pins;
  logic [10:0] ticks;
  logic [7:0] periods;
  logic [7:0] ramp;
  logic [7:0] prescale;
  logic [6:0] duty_q;
  logic       pwm;

  // Any register write puts the run state back to the start of the mode.
  function automatic void restart_run();
    run_state = (regs.mode == rgbl_pkg::MODE_UNUSED) ? rgbl_pkg::MODE_SOLID : regs.mode;
    shown     = COLOR_NONE;
    ticks     = '0;
    periods   = regs.blink_count;
    ramp      = '0;
    prescale  = '0;
    duty_q    = '0;
    pwm       = (run_state == rgbl_pkg::MODE_BREATHE);
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [7:0] data);
    case (idx)
      rgbl_pkg::REG_MODE:        regs.mode = data[1:0];
      rgbl_pkg::REG_BACKGROUND:  regs.background_color = data[2:0];
      rgbl_pkg::REG_FLASH:       regs.blink_color = data[2:0];
      rgbl_pkg::REG_ON_TIME:     regs.on_time = data;
      rgbl_pkg::REG_OFF_TIME:    regs.off_time = data;
      rgbl_pkg::REG_BLINK_COUNT: regs.blink_count = data;
      rgbl_pkg::REG_RISE_SPEED:  regs.rise_speed = data;
      rgbl_pkg::REG_FALL_SPEED:  regs.fall_speed = data;
      default: ;
    endcase
    restart_run();
  endfunction

  // One tick of the blink period: flash at the first tick, background at the
  // end of the on part, and the period closes once its length is reached.
  function automatic void blink_advance();
    int on_end;
    int period_end;
    on_end = 2 * int'(regs.on_time);
    period_end = on_end + 2 * int'(regs.off_time);
    ticks = ticks + 11'd1;
    if (ticks == 11'd1) begin
      pins = ~regs.blink_color;
    end else if (int'(ticks) == on_end) begin
      pins = ~regs.background_color;
    end else if (int'(ticks) >= period_end) begin
      ticks = '0;
      if (periods != 0) periods = periods - 8'd1;
    end
  endfunction

  // Small speeds are a step size, larger ones divide the tick rate.
  function automatic void ramp_step(input logic [7:0] speed, input int limit);
    int next;
    if (speed < rgbl_pkg::SPEED_SPLIT) begin
      next = int'(ramp) + int'(rgbl_pkg::SPEED_SPLIT) - int'(speed);
      if (next > limit) next = limit;
      ramp = 8'(next);
    end else begin
      prescale = prescale + 8'd1;
      if (prescale >= speed - rgbl_pkg::SPEED_SPLIT) begin
        prescale = '0;
        ramp = ramp + 8'd1;
      end
    end
  endfunction

  function automatic void breathe_advance();
    if (ramp < rgbl_pkg::RAMP_MID) begin
      ramp_step(regs.rise_speed, int'(rgbl_pkg::RAMP_MID));
      duty_q = (ramp < rgbl_pkg::SPEED_SPLIT) ? rgbl_pkg::DUTY_FLOOR : ramp[6:0];
    end else if (ramp < rgbl_pkg::RAMP_TOP) begin
      ramp_step(regs.fall_speed, int'(rgbl_pkg::RAMP_TOP));
      duty_q = (ramp > rgbl_pkg::RAMP_HIGH_EDGE) ? rgbl_pkg::DUTY_FLOOR
                                                 : 7'(rgbl_pkg::RAMP_TOP - ramp);
    end else begin
      ramp = '0;
      duty_q = '0;
    end
  endfunction

  function automatic rgbl_pkg::result_t predict_led(input logic t);
    rgbl_pkg::result_t res;
    logic counted;
    if (t) begin
      if (run_state == rgbl_pkg::MODE_BLINK) begin
        counted = (periods != 0);
        blink_advance();
        // A counted run that has just finished drops back to solid mode.
        if (counted && periods == 0) begin
          shown = COLOR_NONE;
          ticks = '0;
          run_state = rgbl_pkg::MODE_SOLID;
          pwm = 1'b0;
        end
      end else if (run_state == rgbl_pkg::MODE_BREATHE) begin
        breathe_advance();
      end else if (shown != {1'b0, regs.background_color}) begin
        pins = ~regs.background_color;
        shown = {1'b0, regs.background_color};
      end
    end
    res.pins_n = pins;
    res.pwm_enable = pwm;
    res.duty = duty_q;
    res.active_mode = run_state;
    return res;
  endfunction

  function automatic void plan_write(input logic [2:0] idx, input logic [7:0] data);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.index = idx;
    row.data = data;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_tick(input logic t);
    plan_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.data = {7'd0, t};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_tick_known(input logic t, input rgbl_pkg::result_t lit);
    plan_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.data = {7'd0, t};
    row.has_lit = 1'b1;
    row.lit = lit;
    plan_q.push_back(row);
  endfunction

  // Registers change only once every result is in and the block is quiet.
  task automatic load_registers();
    in_valid <= 1'b0;
    while (led_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    foreach (pending_writes[k]) begin
      cfg_write <= 1'b1;
      cfg_index <= pending_writes[k][10:8];
      cfg_data  <= pending_writes[k][7:0];
      store_reg(pending_writes[k][10:8], pending_writes[k][7:0]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    pending_writes.delete();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one tick request after a random gap and record what it should return.
  task automatic send_item(input logic t, input logic has_lit,
                           input rgbl_pkg::result_t lit);
    int gap;
    rgbl_pkg::result_t want;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_led(t);
    led_expected_q.push_back(has_lit ? lit : want);
  endtask

  // Result side: compare with the oldest prediction and pace out_ready.
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin : result_side
    rgbl_pkg::result_t got;
    rgbl_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {blue_pin_n, green_pin_n, red_pin_n, pwm_enable, duty, active_mode};
      if (led_expected_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected result: pins %b pwm %b duty %0d mode %0d",
                   got.pins_n, got.pwm_enable, got.duty, got.active_mode);
        fail_count++;
      end else begin
        want = led_expected_q.pop_front();
        if (got !== want) begin
          if (fail_count < MAX_REPORTS)
            $display({"mismatch: expected pins %b pwm %b duty %0d mode %0d,",
                      " got pins %b pwm %b duty %0d mode %0d"},
                     want.pins_n, want.pwm_enable, want.duty, want.active_mode,
                     got.pins_n, got.pwm_enable, got.duty, got.active_mode);
          fail_count++;
        end
      end
    end
    // One long hold-off lets the block fill up and stall its requests.
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (phase_num == HOLD_PHASE && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which nothing moves.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] reg_val [8];
    logic [1:0] mode_code;
    int sel;
    int n_items;
    pace_t pace;

    regs = '0;
    pins = 3'b111;
    restart_run();

    // Directed rows. After reset the LED is dark and solid black keeps it so.
    plan_tick_known(1'b0, {3'b111, 1'b0, 7'd0, rgbl_pkg::MODE_SOLID});
    plan_tick_known(1'b1, {3'b111, 1'b0, 7'd0, rgbl_pkg::MODE_SOLID});
    // Solid white, written with the upper data bits set.
    plan_write(rgbl_pkg::REG_BACKGROUND, 8'hFF);
    plan_tick_known(1'b1, {3'b000, 1'b0, 7'd0, rgbl_pkg::MODE_SOLID});
    plan_tick(1'b0);
    // The unused mode value behaves as solid mode.
    plan_write(rgbl_pkg::REG_MODE, {6'd0, rgbl_pkg::MODE_UNUSED});
    plan_write(rgbl_pkg::REG_BACKGROUND, 8'h02);
    plan_tick_known(1'b1, {3'b101, 1'b0, 7'd0, rgbl_pkg::MODE_SOLID});
    // Two counted blinks with zero on and off times, then back to solid.
    plan_write(rgbl_pkg::REG_MODE, {6'd0, rgbl_pkg::MODE_BLINK});
    plan_write(rgbl_pkg::REG_FLASH, 8'h05);
    plan_write(rgbl_pkg::REG_BLINK_COUNT, 8'd2);
    repeat (5) plan_tick(1'b1);
    // Zero off time, blinking for ever.
    plan_write(rgbl_pkg::REG_ON_TIME, 8'd1);
    plan_write(rgbl_pkg::REG_BLINK_COUNT, 8'd0);
    repeat (4) plan_tick(1'b1);
    plan_tick(1'b0);
    // Breathing at the largest step, then the slowest rising divider.
    plan_write(rgbl_pkg::REG_MODE, {6'd0, rgbl_pkg::MODE_BREATHE});
    plan_tick(1'b0);
    repeat (3) plan_tick(1'b1);
    plan_write(rgbl_pkg::REG_RISE_SPEED, 8'hFF);
    plan_write(rgbl_pkg::REG_FALL_SPEED, 8'd5);
    repeat (2) plan_tick(1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_WRITE) begin
        pending_writes.push_back({plan_q[i].index, plan_q[i].data});
      end else begin
        if (pending_writes.size() != 0) load_registers();
        send_item(plan_q[i].data[0], plan_q[i].has_lit, plan_q[i].lit);
      end
    end

    // Random phases, each with fresh settings and its own pacing.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 0) begin
        foreach (reg_val[k]) reg_val[k] = 8'h00;
      end else if (p <= 2) begin
        foreach (reg_val[k]) reg_val[k] = 8'hFF;
        reg_val[rgbl_pkg::REG_MODE] =
          {6'h3F, (p == 1) ? rgbl_pkg::MODE_BLINK : rgbl_pkg::MODE_BREATHE};
      end else begin
        sel = $urandom_range(0, 9);
        mode_code = (sel < 4) ? rgbl_pkg::MODE_BLINK :
                    (sel < 8) ? rgbl_pkg::MODE_BREATHE :
                    (sel == 8) ? rgbl_pkg::MODE_SOLID : rgbl_pkg::MODE_UNUSED;
        reg_val[rgbl_pkg::REG_MODE]       = {6'($urandom), mode_code};
        reg_val[rgbl_pkg::REG_BACKGROUND] = 8'($urandom);
        reg_val[rgbl_pkg::REG_FLASH]      = 8'($urandom);
        reg_val[rgbl_pkg::REG_ON_TIME]    = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 3));
        reg_val[rgbl_pkg::REG_OFF_TIME]   = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 3));
        reg_val[rgbl_pkg::REG_BLINK_COUNT] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 4));
        reg_val[rgbl_pkg::REG_RISE_SPEED] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 7));
        reg_val[rgbl_pkg::REG_FALL_SPEED] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 7));
      end
      foreach (reg_val[k]) pending_writes.push_back({3'(k), reg_val[k]});
      load_registers();

      pace = pace_t'(p % 4);
      case (pace)
        PACE_SENDER: begin
          send_idle_pct = 80;
          recv_stall_pct = 0;
        end
        PACE_RECEIVER: begin
          send_idle_pct = 0;
          recv_stall_pct = 80;
        end
        PACE_BOTH: begin
          send_idle_pct = 24;
          recv_stall_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_num = p;

      // Breathing needs longer runs for the ramp to reach the top and wrap.
      n_items = (run_state == rgbl_pkg::MODE_BREATHE) ? 75 : 40;
      repeat (n_items) send_item($urandom_range(0, 9) != 0, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (led_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
